// ===== hdl/tmpf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the tile-map pixel fetch.
// No dependencies; every other file of the block uses this package.
package tmpf_pkg;

    // Default store sizes and fixed tile geometry
    localparam int MAP_ENTRIES_DEF = 4096;
    localparam int ATLAS_TILES_DEF = 256;
    localparam int TILE_SIDE       = 8;
    localparam int TILE_BITS       = $clog2(TILE_SIDE);
    localparam int TILE_AREA       = TILE_SIDE * TILE_SIDE;

    // Configuration register indexes
    localparam logic [2:0] REG_PAN_X       = 3'd0;
    localparam logic [2:0] REG_PAN_Y       = 3'd1;
    localparam logic [2:0] REG_MAP_WIDTH   = 3'd2;
    localparam logic [2:0] REG_MAP_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_ATLAS_COUNT = 3'd4;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_MAP_WR   = 2'd0,
        OP_ATLAS_WR = 2'd1,
        OP_RENDER   = 2'd2
    } op_t;

    typedef struct packed {
        logic [15:0] pan_x;
        logic [15:0] pan_y;
        logic [6:0]  map_w;
        logic [6:0]  map_h;
        logic [8:0]  tile_cnt;
    } cfg_t;

    // Payload that travels down the pipeline; each stage fills its own fields
    typedef struct packed {
        op_t                  op;
        logic [11:0]          sx;
        logic [11:0]          sy;
        logic [13:0]          waddr;
        logic [15:0]          wdata;
        logic                 ok;
        logic [TILE_BITS-1:0] fx;
        logic [TILE_BITS-1:0] fy;
        logic [7:0]           hi_x;
        logic [7:0]           lo_x;
        logic [7:0]           hi_y;
        logic [7:0]           lo_y;
        logic [8:0]           rx;
        logic [8:0]           ry;
        logic [16:0]          map_idx;
        logic                 map_hit;
        logic [15:0]          id;
        logic [8:0]           rem;
        logic [18:0]          atlas_idx;
        logic                 atlas_hit;
    } item_t;

    // Eight restoring remainder steps: shifts one byte of dividend into r.
    // Requires r_in < d; the result is again below d.
    function automatic logic [8:0] rem8(input logic [8:0] r_in,
                                        input logic [7:0] chunk,
                                        input logic [8:0] d);
        logic [9:0] r;
        r = {1'b0, r_in};
        for (int i = 7; i >= 0; i--) begin
            r = {r[8:0], chunk[i]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
            end
        end
        return r[8:0];
    endfunction

endpackage

// ===== hdl/tmpf_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result transactions.
// Depends on tmpf_pkg for the operation type.
interface tmpf_req_if;
    logic            valid;
    logic            ready;
    tmpf_pkg::op_t   op;
    logic [11:0]     screen_x;
    logic [11:0]     screen_y;
    logic [13:0]     write_addr;
    logic [15:0]     write_data;

    modport source (output valid, op, screen_x, screen_y, write_addr, write_data,
                    input ready);
    modport sink (input valid, op, screen_x, screen_y, write_addr, write_data,
                  output ready);
endinterface

interface tmpf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       ok;

    modport source (output valid, pixel, ok, input ready);
    modport sink (input valid, pixel, ok, output ready);
endinterface

// ===== hdl/tmpf_wrap.sv =====
`timescale 1ns / 1ps
// Scroll add and wrap of both axes: three stages (add, high remainder byte,
// low remainder byte). Depends on tmpf_pkg.
module tmpf_wrap (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  tmpf_pkg::cfg_t  cfg,
    input  logic            in_vld,
    input  tmpf_pkg::item_t in_item,
    output logic            out_vld,
    output tmpf_pkg::item_t out_item
);

    logic            a_vld_reg, b_vld_reg, c_vld_reg;
    tmpf_pkg::item_t a_reg, b_reg, c_reg;
    tmpf_pkg::item_t a_next, b_next, c_next;
    logic [16:0]     sum_x, sum_y;

    // Stage A: add scroll, split into in-tile bits and tile-unit dividend
    always_comb
    begin
        a_next      = in_item;
        sum_x       = {5'b0, in_item.sx} + {1'b0, cfg.pan_x};
        sum_y       = {5'b0, in_item.sy} + {1'b0, cfg.pan_y};
        a_next.fx   = sum_x[tmpf_pkg::TILE_BITS-1:0];
        a_next.fy   = sum_y[tmpf_pkg::TILE_BITS-1:0];
        a_next.hi_x = {2'b0, sum_x[16:11]};
        a_next.lo_x = sum_x[10:3];
        a_next.hi_y = {2'b0, sum_y[16:11]};
        a_next.lo_y = sum_y[10:3];
        a_next.ok   = (cfg.map_w != '0) && (cfg.map_h != '0) && (cfg.tile_cnt != '0);
    end

    // Stage B: remainder over the high byte
    always_comb
    begin
        b_next    = a_reg;
        b_next.rx = tmpf_pkg::rem8(9'd0, a_reg.hi_x, {2'b0, cfg.map_w});
        b_next.ry = tmpf_pkg::rem8(9'd0, a_reg.hi_y, {2'b0, cfg.map_h});
    end

    // Stage C: remainder over the low byte gives the tile coordinate
    always_comb
    begin
        c_next    = b_reg;
        c_next.rx = tmpf_pkg::rem8(b_reg.rx, b_reg.lo_x, {2'b0, cfg.map_w});
        c_next.ry = tmpf_pkg::rem8(b_reg.ry, b_reg.lo_y, {2'b0, cfg.map_h});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    assign out_vld  = c_vld_reg;
    assign out_item = c_reg;

endmodule

// ===== hdl/tmpf_map.sv =====
`timescale 1ns / 1ps
// Map index computation and tile-id store (write or registered read).
// Depends on tmpf_pkg.
module tmpf_map #(
    parameter int MAP_ENTRIES = tmpf_pkg::MAP_ENTRIES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  tmpf_pkg::cfg_t  cfg,
    input  logic            in_vld,
    input  tmpf_pkg::item_t in_item,
    output logic            out_vld,
    output tmpf_pkg::item_t out_item
);

    localparam int MAW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam logic [16:0] MAP_LIMIT = 17'(MAP_ENTRIES);

    logic [15:0]     map_mem [MAP_ENTRIES];
    logic [15:0]     rd_reg;
    logic            d_vld_reg, e_vld_reg;
    tmpf_pkg::item_t d_reg, e_reg;
    tmpf_pkg::item_t d_next;
    logic [13:0]     prod;

    // Stage D: row-major map index, range check
    always_comb
    begin
        d_next = in_item;
        prod   = ({7'b0, in_item.ry[6:0]} * {7'b0, cfg.map_w}) + {7'b0, in_item.rx[6:0]};
        if (in_item.op == tmpf_pkg::OP_RENDER)
        begin
            d_next.map_idx = {3'b0, prod};
        end
        else
        begin
            d_next.map_idx = {3'b0, in_item.waddr};
        end
        d_next.map_hit = d_next.map_idx < MAP_LIMIT;
    end

    // Stage E: tile-id store
    always_ff @(posedge clk)
    begin
        if (adv && d_vld_reg && d_reg.map_hit)
        begin
            if (d_reg.op == tmpf_pkg::OP_MAP_WR)
            begin
                map_mem[d_reg.map_idx[MAW-1:0]] <= d_reg.wdata;
            end
            else if (d_reg.op == tmpf_pkg::OP_RENDER)
            begin
                rd_reg <= map_mem[d_reg.map_idx[MAW-1:0]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_vld_reg <= in_vld;
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
            e_reg <= d_reg;
        end
    end

    // Out-of-range map index reads as tile 0
    always_comb
    begin
        out_item    = e_reg;
        out_item.id = e_reg.map_hit ? rd_reg : 16'd0;
    end

    assign out_vld = e_vld_reg;

endmodule

// ===== hdl/tmpf_atlas.sv =====
`timescale 1ns / 1ps
// Tile-id reduction modulo the atlas count (two stages) and atlas pixel store.
// Depends on tmpf_pkg.
module tmpf_atlas #(
    parameter int ATLAS_TILES = tmpf_pkg::ATLAS_TILES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  tmpf_pkg::cfg_t  cfg,
    input  logic            in_vld,
    input  tmpf_pkg::item_t in_item,
    output logic            out_vld,
    output tmpf_pkg::item_t out_item,
    output logic [7:0]      pix_rd
);

    localparam int ATLAS_BYTES = ATLAS_TILES * tmpf_pkg::TILE_AREA;
    localparam int AAW = $clog2(ATLAS_BYTES);
    localparam logic [18:0] ATLAS_LIMIT = 19'(ATLAS_BYTES);

    logic [7:0]      atlas_mem [ATLAS_BYTES];
    logic [7:0]      rd_reg;
    logic            f_vld_reg, g_vld_reg, h_vld_reg;
    tmpf_pkg::item_t f_reg, g_reg, h_reg;
    tmpf_pkg::item_t f_next, g_next;

    // Stage F: remainder of tile id, high byte
    always_comb
    begin
        f_next     = in_item;
        f_next.rem = tmpf_pkg::rem8(9'd0, in_item.id[15:8], cfg.tile_cnt);
    end

    // Stage G: low byte, then atlas byte address and range check
    always_comb
    begin
        g_next     = f_reg;
        g_next.rem = tmpf_pkg::rem8(f_reg.rem, f_reg.id[7:0], cfg.tile_cnt);
        if (f_reg.op == tmpf_pkg::OP_RENDER)
        begin
            g_next.atlas_idx = {4'b0, g_next.rem, f_reg.fy, f_reg.fx};
        end
        else
        begin
            g_next.atlas_idx = {5'b0, f_reg.waddr};
        end
        g_next.atlas_hit = g_next.atlas_idx < ATLAS_LIMIT;
    end

    // Stage H: atlas store
    always_ff @(posedge clk)
    begin
        if (adv && g_vld_reg && g_reg.atlas_hit)
        begin
            if (g_reg.op == tmpf_pkg::OP_ATLAS_WR)
            begin
                atlas_mem[g_reg.atlas_idx[AAW-1:0]] <= g_reg.wdata[7:0];
            end
            else if (g_reg.op == tmpf_pkg::OP_RENDER)
            begin
                rd_reg <= atlas_mem[g_reg.atlas_idx[AAW-1:0]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_vld_reg <= in_vld;
            g_vld_reg <= f_vld_reg;
            h_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_reg <= f_next;
            g_reg <= g_next;
            h_reg <= g_reg;
        end
    end

    assign out_vld  = h_vld_reg;
    assign out_item = h_reg;
    assign pix_rd   = rd_reg;

endmodule

// ===== hdl/wrapped_tilemap_pixel_fetch.sv =====
`timescale 1ns / 1ps
// Top level of the wrapped tile-map pixel fetch: config registers, pipeline,
// output register. Depends on tmpf_pkg, tmpf_if, tmpf_wrap, tmpf_map, tmpf_atlas.
//
// Usage: req carries one transaction per item: map write, atlas write or
// render. Writes produce nothing on rsp; each render produces one rsp
// transaction (pixel, ok). Configuration is written through wr_en/wr_index/
// wr_data while the block is idle; indexes beyond the list are ignored.
// A render passes eight pipeline stages, then the output register.
// Throughput: one item per cycle while the receiver does not stall;
// the modulo reductions are split into byte-wide remainder stages and each
// store is accessed once per item at its own stage, so writes and renders
// keep program order.
// Reset clears the configuration to zero and all valid bits; store contents
// are undefined until written. When the receiver stalls, the whole pipeline
// holds and req.ready drops only while a result waits in the output register
// unaccepted; nothing is lost or repeated.
module wrapped_tilemap_pixel_fetch #(
    parameter int MAP_ENTRIES = tmpf_pkg::MAP_ENTRIES_DEF,
    parameter int ATLAS_TILES = tmpf_pkg::ATLAS_TILES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tmpf_req_if.sink    req,
    tmpf_rsp_if.source  rsp,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [15:0] wr_data
);

    tmpf_pkg::cfg_t  cfg_reg;
    logic            adv;
    tmpf_pkg::item_t in_item;
    logic            w_vld, m_vld, h_vld;
    tmpf_pkg::item_t w_item, m_item, h_item;
    logic [7:0]      pix_rd;
    logic            out_vld_reg;
    logic [7:0]      pixel_reg;
    logic            ok_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                tmpf_pkg::REG_PAN_X:       cfg_reg.pan_x    <= wr_data;
                tmpf_pkg::REG_PAN_Y:       cfg_reg.pan_y    <= wr_data;
                tmpf_pkg::REG_MAP_WIDTH:   cfg_reg.map_w    <= wr_data[6:0];
                tmpf_pkg::REG_MAP_HEIGHT:  cfg_reg.map_h    <= wr_data[6:0];
                tmpf_pkg::REG_ATLAS_COUNT: cfg_reg.tile_cnt <= wr_data[8:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline moves when the output register is free or being taken
    assign adv       = !out_vld_reg || rsp.ready;
    assign req.ready = adv;

    always_comb
    begin
        in_item       = '0;
        in_item.op    = req.op;
        in_item.sx    = req.screen_x;
        in_item.sy    = req.screen_y;
        in_item.waddr = req.write_addr;
        in_item.wdata = req.write_data;
    end

    tmpf_wrap u_wrap (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg      (cfg_reg),
        .in_vld   (req.valid),
        .in_item  (in_item),
        .out_vld  (w_vld),
        .out_item (w_item)
    );

    tmpf_map #(.MAP_ENTRIES(MAP_ENTRIES)) u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg      (cfg_reg),
        .in_vld   (w_vld),
        .in_item  (w_item),
        .out_vld  (m_vld),
        .out_item (m_item)
    );

    tmpf_atlas #(.ATLAS_TILES(ATLAS_TILES)) u_atlas (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg      (cfg_reg),
        .in_vld   (m_vld),
        .in_item  (m_item),
        .out_vld  (h_vld),
        .out_item (h_item),
        .pix_rd   (pix_rd)
    );

    // Output register: only renders leave a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= h_vld && (h_item.op == tmpf_pkg::OP_RENDER);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pixel_reg <= (h_item.ok && h_item.atlas_hit) ? pix_rd : 8'd0;
            ok_reg    <= h_item.ok;
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.pixel = pixel_reg;
    assign rsp.ok    = ok_reg;

    // Checks
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !ok_reg |-> pixel_reg == 8'd0)
        else $error("invalid result with nonzero pixel");

    a_render_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv && h_vld && (h_item.op == tmpf_pkg::OP_RENDER) |=> out_vld_reg)
        else $error("render lost at output register");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !(h_vld && (h_item.op == tmpf_pkg::OP_RENDER)) |=> !out_vld_reg)
        else $error("result without render");

    a_ok_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && ok_reg |->
            (cfg_reg.map_w != '0) && (cfg_reg.map_h != '0) && (cfg_reg.tile_cnt != '0))
        else $error("ok set with zero configuration");

endmodule
